FILE: rtl/smpr_pkg.sv
// Package: request codes, sequencer states and result record for the sparse row product.
package smpr_pkg;

   typedef enum logic [1:0] {
      REQ_LOAD_A  = 2'd0,
      REQ_LOAD_B  = 2'd1,
      REQ_COMPUTE = 2'd2,
      REQ_CLEAR   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COL,
      ST_FETCH,
      ST_CMP,
      ST_ACC,
      ST_EMIT,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic [3:0]  col;
      logic [63:0] sum;
      logic        empty_res;
      logic        saturated;
      logic        load_error;
      logic        last;
   } result_type;

   localparam int VALUE_W = 32;
   localparam int ACC_W   = 64;

endpackage

FILE: rtl/sparse_matrix_product_row_unit.sv
// Top level: sparse matrix row product (CSR row of A against CSC columns of B).
// Loads and clear are taken in the idle state. A compute request walks the product columns
// 0..min(b_cols,MAX_DIM,16)-1 one after another. Each column has a setup step, a
// store read and then a compare for each merge step, a multiply/accumulate step for each
// matching index, a final read that ends the walk and a step that hands off the sum.
// A nonzero sum is parked until the next nonzero sum or the wrap-up, so that the
// last marker lands on the final one; the wrap-up step then hands over the parked
// result or the empty result. The single-port A and B entry memories and the one
// shared multiplier set this pacing, and a result not yet taken by the receiver
// stalls the walk. req_tready is low for the whole of a compute request and while
// a result waits. A row at or beyond MAX_DIM skips the walk and gives the empty result.
module sparse_matrix_product_row_unit #(
   parameter int MAX_DIM     = 16,
   parameter int MAX_ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [4:0]   csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: major[3:0], minor[7:4], value[39:8]
   input  logic [39:0]  req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: col[3:0], sum[67:4], zero fill [71:68]
   output logic [71:0]  rsp_tdata,
   // tuser: empty_res[0], saturated[1], load_error[2]
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast
);
   localparam int PW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int COL_LIM = (MAX_DIM < 16) ? MAX_DIM : 16;

   logic [4:0] bcols_ff;
   always_ff @(posedge clock) begin
      if (reset) bcols_ff <= 5'd16;
      else if (csr_we) bcols_ff <= csr_wdata;
   end

   logic [3:0]  in_major, in_minor;
   logic [31:0] in_value;
   assign in_major = req_tdata[3:0];
   assign in_minor = req_tdata[7:4];
   assign in_value = req_tdata[39:8];

   logic [3:0]  a_idx_mem [MAX_ENTRIES];
   logic [31:0] a_val_mem [MAX_ENTRIES];
   logic [3:0]  b_idx_mem [MAX_ENTRIES];
   logic [31:0] b_val_mem [MAX_ENTRIES];
   logic [PW-1:0] a_ptr_ff [MAX_DIM+1];
   logic [PW-1:0] b_ptr_ff [MAX_DIM+1];
   logic [PW-1:0] a_fill_ff, b_fill_ff;
   logic [3:0]    a_lastidx_ff, b_lastidx_ff;
   logic          err_ff;

   smpr_pkg::state_type state_ff, state_in;
   logic [3:0]    row_ff;
   logic [DW-1:0] col_ff;
   logic [PW-1:0] k_ff, ke_ff, l_ff, le_ff;
   logic [3:0]    ka_ff, lb_ff;
   logic [31:0]   av_ff, bv_ff;
   logic          pend_valid_ff;
   smpr_pkg::result_type pend_ff;
   logic          out_valid_ff;
   smpr_pkg::result_type out_ff;
   logic          row_ok;

   logic accept;
   assign accept = req_tvalid && req_tready;

   logic [DW-1:0] ncols;
   always_comb begin
      if (32'(bcols_ff) > COL_LIM) ncols = DW'(COL_LIM);
      else ncols = DW'(bcols_ff);
   end
   assign row_ok = 32'(row_ff) < MAX_DIM;

   // load legality
   logic ld_a, ld_b, ok_a, ok_b;
   assign ld_a = accept && (req_tuser == smpr_pkg::REQ_LOAD_A);
   assign ld_b = accept && (req_tuser == smpr_pkg::REQ_LOAD_B);

   function automatic logic load_ok(input logic [3:0] maj, input logic [3:0] mnr,
                                    input logic [PW-1:0] fill,
                                    input logic [PW-1:0] p_lo,
                                    input logic [PW-1:0] p_hi,
                                    input logic [3:0] lastidx);
      logic ok;
      ok = (32'(maj) < MAX_DIM) && (32'(mnr) < MAX_DIM) && (32'(fill) < MAX_ENTRIES);
      if (ok && p_hi != fill) ok = 1'b0;
      if (ok && p_lo != fill && mnr <= lastidx) ok = 1'b0;
      return ok;
   endfunction

   logic [DW-1:0] maj_d, maj_d1;
   assign maj_d  = DW'(in_major);
   assign maj_d1 = DW'(in_major) + DW'(1);

   always_comb begin
      ok_a = 1'b0;
      ok_b = 1'b0;
      if (32'(in_major) < MAX_DIM) begin
         ok_a = load_ok(in_major, in_minor, a_fill_ff, a_ptr_ff[maj_d], a_ptr_ff[maj_d1],
                        a_lastidx_ff);
         ok_b = load_ok(in_major, in_minor, b_fill_ff, b_ptr_ff[maj_d], b_ptr_ff[maj_d1],
                        b_lastidx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ld_a && ok_a) begin
         a_idx_mem[a_fill_ff[AW-1:0]] <= in_minor;
         a_val_mem[a_fill_ff[AW-1:0]] <= in_value;
      end
      if (ld_b && ok_b) begin
         b_idx_mem[b_fill_ff[AW-1:0]] <= in_minor;
         b_val_mem[b_fill_ff[AW-1:0]] <= in_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_tuser == smpr_pkg::REQ_CLEAR)) begin
         for (int q = 0; q <= MAX_DIM; q++) begin
            a_ptr_ff[q] <= '0;
            b_ptr_ff[q] <= '0;
         end
         a_fill_ff <= '0;
         b_fill_ff <= '0;
         err_ff    <= 1'b0;
      end else begin
         if (ld_a) begin
            if (ok_a) begin
               a_fill_ff    <= a_fill_ff + PW'(1);
               a_lastidx_ff <= in_minor;
               for (int q = 1; q <= MAX_DIM; q++)
                  if (q > 32'(in_major)) a_ptr_ff[q] <= a_fill_ff + PW'(1);
            end else err_ff <= 1'b1;
         end
         if (ld_b) begin
            if (ok_b) begin
               b_fill_ff    <= b_fill_ff + PW'(1);
               b_lastidx_ff <= in_minor;
               for (int q = 1; q <= MAX_DIM; q++)
                  if (q > 32'(in_major)) b_ptr_ff[q] <= b_fill_ff + PW'(1);
            end else err_ff <= 1'b1;
         end
      end
   end

   // shared multiply-accumulate
   logic mac_clear, mac_mul, mac_acc;
   logic signed [63:0] acc;
   logic mac_sat;
   smpr_mac u_mac (
      .clock (clock), .clear (mac_clear), .mul_en (mac_mul), .acc_en (mac_acc),
      .a_val (av_ff), .b_val (bv_ff), .acc (acc), .sat (mac_sat)
   );

   logic walk_more, col_done_last;
   assign walk_more = (k_ff < ke_ff) && (l_ff < le_ff);
   assign col_done_last = (col_ff + DW'(1)) >= ncols;
   logic out_free;
   assign out_free = !out_valid_ff || rsp_tready;

   // a new nonzero sum must push the parked one out first
   logic emit_stall, out_load;
   assign emit_stall = (state_ff == smpr_pkg::ST_EMIT) && (acc != 64'sd0) &&
                       pend_valid_ff && !out_free;
   assign out_load = ((state_ff == smpr_pkg::ST_EMIT) && !emit_stall &&
                      (acc != 64'sd0) && pend_valid_ff) ||
                     ((state_ff == smpr_pkg::ST_EMPTY) && out_free);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smpr_pkg::ST_IDLE:
            if (accept && req_tuser == smpr_pkg::REQ_COMPUTE) state_in = smpr_pkg::ST_COL;
         smpr_pkg::ST_COL:
            if (!row_ok || col_ff >= ncols) state_in = smpr_pkg::ST_EMPTY;
            else state_in = smpr_pkg::ST_FETCH;
         smpr_pkg::ST_FETCH:
            if (walk_more) state_in = smpr_pkg::ST_CMP;
            else state_in = smpr_pkg::ST_EMIT;
         smpr_pkg::ST_CMP:
            if (ka_ff == lb_ff) state_in = smpr_pkg::ST_ACC;
            else state_in = smpr_pkg::ST_FETCH;
         smpr_pkg::ST_ACC: state_in = smpr_pkg::ST_FETCH;
         smpr_pkg::ST_EMIT:
            if (!emit_stall) begin
               if (col_done_last) state_in = smpr_pkg::ST_EMPTY;
               else state_in = smpr_pkg::ST_COL;
            end
         // wrap-up: parked result with last, or the empty result
         smpr_pkg::ST_EMPTY:
            if (out_free) state_in = smpr_pkg::ST_IDLE;
         default: state_in = smpr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mac_clear = state_ff == smpr_pkg::ST_COL;
      mac_mul   = state_ff == smpr_pkg::ST_CMP;
      mac_acc   = state_ff == smpr_pkg::ST_ACC;
      req_tready = (state_ff == smpr_pkg::ST_IDLE) && !out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= smpr_pkg::ST_IDLE;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
         case (state_ff)
            smpr_pkg::ST_IDLE:
               if (accept) begin
                  row_ff <= in_major;
                  col_ff <= '0;
               end
            smpr_pkg::ST_COL: begin
               k_ff  <= a_ptr_ff[DW'(row_ff)];
               ke_ff <= a_ptr_ff[DW'(row_ff) + DW'(1)];
               l_ff  <= b_ptr_ff[col_ff];
               le_ff <= b_ptr_ff[col_ff + DW'(1)];
            end
            smpr_pkg::ST_FETCH: begin
               ka_ff <= a_idx_mem[k_ff[AW-1:0]];
               av_ff <= a_val_mem[k_ff[AW-1:0]];
               lb_ff <= b_idx_mem[l_ff[AW-1:0]];
               bv_ff <= b_val_mem[l_ff[AW-1:0]];
            end
            smpr_pkg::ST_CMP:
               if (ka_ff < lb_ff) k_ff <= k_ff + PW'(1);
               else if (ka_ff > lb_ff) l_ff <= l_ff + PW'(1);
               else begin
                  k_ff <= k_ff + PW'(1);
                  l_ff <= l_ff + PW'(1);
               end
            smpr_pkg::ST_EMIT:
               if (!emit_stall) begin
                  col_ff <= col_ff + DW'(1);
                  if (acc != 64'sd0) begin
                     if (pend_valid_ff) out_ff <= pend_ff;
                     pend_valid_ff <= 1'b1;
                     pend_ff <= '{col: col_ff[3:0], sum: acc, empty_res: 1'b0,
                                  saturated: mac_sat, load_error: err_ff, last: 1'b0};
                  end
               end
            smpr_pkg::ST_EMPTY:
               if (out_free) begin
                  pend_valid_ff <= 1'b0;
                  if (pend_valid_ff) begin
                     out_ff.col        <= pend_ff.col;
                     out_ff.sum        <= pend_ff.sum;
                     out_ff.empty_res  <= 1'b0;
                     out_ff.saturated  <= pend_ff.saturated;
                     out_ff.load_error <= pend_ff.load_error;
                  end else begin
                     out_ff.col        <= '0;
                     out_ff.sum        <= '0;
                     out_ff.empty_res  <= 1'b1;
                     out_ff.saturated  <= 1'b0;
                     out_ff.load_error <= err_ff;
                  end
                  out_ff.last <= 1'b1;
               end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.sum, out_ff.col};
   assign rsp_tuser  = {out_ff.load_error, out_ff.saturated, out_ff.empty_res};
   assign rsp_tlast  = out_ff.last;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != smpr_pkg::ST_IDLE) |-> !req_tready)
      else $error("request taken while busy");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(a_fill_ff) <= MAX_ENTRIES) && (32'(b_fill_ff) <= MAX_ENTRIES))
      else $error("fill beyond capacity");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smpr_pkg::ST_CMP) |-> (k_ff < ke_ff && l_ff < le_ff))
      else $error("merge walked past its run");
endmodule

FILE: rtl/smpr_mac.sv
// Module: registered signed multiply feeding a saturating 64-bit accumulator.
module smpr_mac (
   input  logic                                clock,
   input  logic                                clear,
   input  logic                                mul_en,
   input  logic                                acc_en,
   input  logic signed [smpr_pkg::VALUE_W-1:0] a_val,
   input  logic signed [smpr_pkg::VALUE_W-1:0] b_val,
   output logic signed [smpr_pkg::ACC_W-1:0]   acc,
   output logic                                sat
);
   logic signed [smpr_pkg::ACC_W-1:0] prod_ff, prod_in;
   logic signed [smpr_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic                              sat_ff, sat_in;
   logic signed [smpr_pkg::ACC_W-1:0] raw;
   logic                              ovf;

   assign prod_in = 64'(a_val) * 64'(b_val);
   assign raw     = acc_ff + prod_ff;
   // overflow when both operands agree in sign and the sum does not
   assign ovf     = (acc_ff[63] == prod_ff[63]) && (raw[63] != acc_ff[63]);

   always_comb begin
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (clear) begin
         acc_in = '0;
         sat_in = 1'b0;
      end else if (acc_en) begin
         if (ovf) begin
            sat_in = 1'b1;
            acc_in = prod_ff[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         end else begin
            acc_in = raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) prod_ff <= prod_in;
      acc_ff <= acc_in;
      sat_ff <= sat_in;
   end

   assign acc = acc_ff;
   assign sat = sat_ff;
endmodule
